// File: rtl/trup_pkg.sv
// Tile update record parser: shared types and constants.
// Used by the channel interfaces and every module of the block.
package trup_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CoordW = 16;
  localparam int unsigned LevelW = 2;
  localparam int unsigned CountW = 5;
  localparam int unsigned NibW   = 4;

  // Packet header flags byte
  localparam int unsigned FlgAllZeroBit = 7;
  localparam int unsigned FlgLevelLsb   = 5;
  // Entry flag byte
  localparam int unsigned EflTypeBit    = 7;

  localparam logic [ByteW-1:0] TypeNone = 8'hFF;

  // Parse phase, one-hot
  typedef enum logic [9:0] {
    PH_X0     = 10'b00_0000_0001,
    PH_X1     = 10'b00_0000_0010,
    PH_Z0     = 10'b00_0000_0100,
    PH_Z1     = 10'b00_0000_1000,
    PH_FLAGS  = 10'b00_0001_0000,
    PH_XZ     = 10'b00_0010_0000,
    PH_EFLAG  = 10'b00_0100_0000,
    PH_HEIGHT = 10'b00_1000_0000,
    PH_TYPE   = 10'b01_0000_0000,
    PH_DATA   = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] stream_byte;
    logic             packet_start;
  } item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] chunk_x;
    logic signed [CoordW-1:0] chunk_z;
    logic [LevelW-1:0]        level_index;
    logic [CountW-1:0]        entry_index;
    logic [NibW-1:0]          column_x;
    logic [NibW-1:0]          column_z;
    logic [ByteW-1:0]         height;
    logic [ByteW-1:0]         block_type;
    logic [ByteW-1:0]         block_data;
    logic                     last_entry;
  } result_t;

  // Parser handshake toward the input and output stages
  typedef struct packed {
    logic step;   // held input byte consumed this cycle
    logic emit;   // result loaded into the output register
  } step_ctl_t;

  function automatic logic [CoordW-1:0] sext8(input logic [ByteW-1:0] b);
    sext8 = {{(CoordW-ByteW){b[ByteW-1]}}, b};
  endfunction

endpackage

// File: rtl/trup_if.sv
// Tile update record parser: valid/ready channel interfaces.
// Depends on trup_pkg for field widths.
interface trup_in_if;
  import trup_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] stream_byte;
  logic             packet_start;

  modport source (output valid, output stream_byte, output packet_start, input ready);
  modport sink   (input valid, input stream_byte, input packet_start, output ready);
endinterface

interface trup_out_if;
  import trup_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] chunk_x;
  logic signed [CoordW-1:0] chunk_z;
  logic [LevelW-1:0]        level_index;
  logic [CountW-1:0]        entry_index;
  logic [NibW-1:0]          column_x;
  logic [NibW-1:0]          column_z;
  logic [ByteW-1:0]         height;
  logic [ByteW-1:0]         block_type;
  logic [ByteW-1:0]         block_data;
  logic                     last_entry;

  modport source (output valid, output chunk_x, output chunk_z, output level_index,
                  output entry_index, output column_x, output column_z, output height,
                  output block_type, output block_data, output last_entry, input ready);
  modport sink   (input valid, input chunk_x, input chunk_z, input level_index,
                  input entry_index, input column_x, input column_z, input height,
                  input block_type, input block_data, input last_entry, output ready);
endinterface

// File: rtl/trup_in_stage.sv
// Tile update record parser: input register holding one stream byte.
// Depends on trup_pkg; released by the parser's step strobe.
module trup_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  trup_pkg::item_t    in_item,
  input  trup_pkg::step_ctl_t ctl,
  output logic               item_valid,
  output trup_pkg::item_t    item
);
  import trup_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready = !valid_r || ctl.step;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (ctl.step) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;
endmodule

// File: rtl/trup_parser.sv
// Tile update record parser: packet state machine and field decode.
// Depends on trup_pkg; sits between trup_in_stage and trup_out_stage.
module trup_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wide_coordinates,
  input  logic                item_valid,
  input  trup_pkg::item_t     item,
  input  logic                out_free,
  output trup_pkg::step_ctl_t ctl,
  output trup_pkg::result_t   result
);
  import trup_pkg::*;

  phase_t            phase_r, phase_nxt, ph;
  logic [CoordW-1:0] coord_x_r, coord_x_nxt;
  logic [CoordW-1:0] coord_z_r, coord_z_nxt;
  logic [LevelW-1:0] level_r, level_nxt;
  logic [CountW-1:0] total_r, total_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic              azd_r, azd_nxt;
  logic [ByteW-1:0]  ctype_r, ctype_nxt;
  logic [ByteW-1:0]  xz_r, xz_nxt;
  logic              tfollow_r, tfollow_nxt;
  logic [ByteW-1:0]  height_r, height_nxt;

  logic [ByteW-1:0]  b;
  logic              emit_c;
  logic [ByteW-1:0]  data_c;
  logic [ByteW-1:0]  type_out;
  logic [ByteW-1:0]  height_out;
  logic              last_c;
  logic              step;

  assign b  = item.stream_byte;
  assign ph = item.packet_start ? PH_X0 : phase_r;

  // Last entry when counter + 1 reaches the total
  assign last_c = ({1'b0, count_r} + {{CountW{1'b0}}, 1'b1}) >= {1'b0, total_r};

  always_comb begin
    phase_nxt   = phase_r;
    coord_x_nxt = coord_x_r;
    coord_z_nxt = coord_z_r;
    level_nxt   = level_r;
    total_nxt   = total_r;
    count_nxt   = count_r;
    azd_nxt     = azd_r;
    ctype_nxt   = ctype_r;
    xz_nxt      = xz_r;
    tfollow_nxt = tfollow_r;
    height_nxt  = height_r;
    emit_c      = 1'b0;
    data_c      = '0;
    type_out    = ctype_r;
    height_out  = height_r;
    unique case (ph)
      PH_X1: begin
        coord_x_nxt = {coord_x_r[CoordW-1:ByteW], b};
        phase_nxt   = PH_Z0;
      end
      PH_Z0: begin
        if (wide_coordinates) begin
          coord_z_nxt = {b, {ByteW{1'b0}}};
          phase_nxt   = PH_Z1;
        end else begin
          coord_z_nxt = sext8(b);
          phase_nxt   = PH_FLAGS;
        end
      end
      PH_Z1: begin
        coord_z_nxt = {coord_z_r[CoordW-1:ByteW], b};
        phase_nxt   = PH_FLAGS;
      end
      PH_FLAGS: begin
        azd_nxt   = b[FlgAllZeroBit];
        level_nxt = b[FlgLevelLsb +: LevelW];
        total_nxt = b[CountW-1:0];
        count_nxt = '0;
        ctype_nxt = TypeNone;
        phase_nxt = (b[CountW-1:0] == '0) ? PH_X0 : PH_XZ;
      end
      PH_XZ: begin
        xz_nxt    = b;
        phase_nxt = PH_EFLAG;
      end
      PH_EFLAG: begin
        tfollow_nxt = b[EflTypeBit];
        phase_nxt   = PH_HEIGHT;
      end
      PH_HEIGHT: begin
        height_nxt = b;
        height_out = b;
        if (tfollow_r) begin
          phase_nxt = PH_TYPE;
        end else if (azd_r) begin
          emit_c = 1'b1;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_TYPE: begin
        ctype_nxt = b;
        type_out  = b;
        if (azd_r) begin
          emit_c = 1'b1;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        emit_c = 1'b1;
        data_c = b;
      end
      default: begin
        // first header byte
        ctype_nxt = TypeNone;
        count_nxt = '0;
        if (wide_coordinates) begin
          coord_x_nxt = {b, {ByteW{1'b0}}};
          phase_nxt   = PH_X1;
        end else begin
          coord_x_nxt = sext8(b);
          phase_nxt   = PH_Z0;
        end
      end
    endcase
    if (emit_c) begin
      if (last_c) begin
        phase_nxt = PH_X0;
        count_nxt = '0;
      end else begin
        phase_nxt = PH_XZ;
        count_nxt = count_r + 1'b1;
      end
    end
  end

  // Bytes that produce nothing never wait on the output register
  assign step     = item_valid && (!emit_c || out_free);
  assign ctl.step = step;
  assign ctl.emit = step && emit_c;

  always_comb begin
    result.chunk_x     = coord_x_r;
    result.chunk_z     = coord_z_r;
    result.level_index = level_r;
    result.entry_index = count_r;
    result.column_x    = xz_r[ByteW-1:NibW];
    result.column_z    = xz_r[NibW-1:0];
    result.height      = height_out;
    result.block_type  = type_out;
    result.block_data  = data_c;
    result.last_entry  = last_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_X0;
      coord_x_r <= '0;
      coord_z_r <= '0;
      level_r   <= '0;
      total_r   <= '0;
      count_r   <= '0;
      azd_r     <= 1'b0;
      ctype_r   <= TypeNone;
      xz_r      <= '0;
      tfollow_r <= 1'b0;
      height_r  <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      coord_x_r <= coord_x_nxt;
      coord_z_r <= coord_z_nxt;
      level_r   <= level_nxt;
      total_r   <= total_nxt;
      count_r   <= count_nxt;
      azd_r     <= azd_nxt;
      ctype_r   <= ctype_nxt;
      xz_r      <= xz_nxt;
      tfollow_r <= tfollow_nxt;
      height_r  <= height_nxt;
    end
  end
endmodule

// File: rtl/trup_out_stage.sv
// Tile update record parser: output register for one result.
// Depends on trup_pkg; loaded on the parser's emit strobe.
module trup_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  trup_pkg::step_ctl_t ctl,
  input  trup_pkg::result_t   result,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                out_free,
  output trup_pkg::result_t   out_result
);
  import trup_pkg::*;

  logic    valid_r, valid_nxt;
  result_t result_r;

  assign out_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.emit) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;
endmodule

// File: rtl/tile_update_record_parser.sv
// Tile update record parser, top level.
// Depends on trup_pkg, trup_if, trup_in_stage, trup_parser, trup_out_stage.
//
// Input channel in_ch: one stream byte per transfer plus packet_start, which
// forces that byte to be taken as the first header byte of a new packet.
// Output channel out_ch: one result per packet entry, on the byte that
// completes the entry; header bytes and zero-count packets give nothing.
// cfg_*: write of wide_coordinates (1 = 16-bit big-endian coordinates); it is
// always ready and should only be written while the block is idle.
//
// Throughput: one byte per cycle while no entry-closing byte waits on a full
// output register. A byte is held in the input register, is decoded by the
// parser and, if it closes an entry, is loaded into the output register,
// which drives out_ch.valid.
// A stalled receiver holds one result in the output register; bytes that
// produce no result keep flowing, and the next entry-closing byte waits in
// the input register, which then backpressures in_ch.
// Reset (rst_n low, synchronous) empties both registers, clears the register
// to narrow coordinates and puts the parser at the first header byte.
module tile_update_record_parser (
  input  logic  clk,
  input  logic  rst_n,
  trup_in_if.sink    in_ch,
  trup_out_if.source out_ch,
  input  logic  cfg_valid,
  output logic  cfg_ready,
  input  logic  cfg_wide_coordinates
);
  import trup_pkg::*;

  logic      wide_r;
  item_t     in_item;
  item_t     item;
  logic      item_valid;
  logic      out_free;
  step_ctl_t ctl;
  result_t   result;
  result_t   out_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      wide_r <= cfg_wide_coordinates;
    end
  end

  assign in_item.stream_byte  = in_ch.stream_byte;
  assign in_item.packet_start = in_ch.packet_start;

  trup_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .ctl        (ctl),
    .item_valid (item_valid),
    .item       (item)
  );

  trup_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .wide_coordinates (wide_r),
    .item_valid       (item_valid),
    .item             (item),
    .out_free         (out_free),
    .ctl              (ctl),
    .result           (result)
  );

  trup_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .result     (result),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_free   (out_free),
    .out_result (out_result)
  );

  assign out_ch.chunk_x     = out_result.chunk_x;
  assign out_ch.chunk_z     = out_result.chunk_z;
  assign out_ch.level_index = out_result.level_index;
  assign out_ch.entry_index = out_result.entry_index;
  assign out_ch.column_x    = out_result.column_x;
  assign out_ch.column_z    = out_result.column_z;
  assign out_ch.height      = out_result.height;
  assign out_ch.block_type  = out_result.block_type;
  assign out_ch.block_data  = out_result.block_data;
  assign out_ch.last_entry  = out_result.last_entry;

  // A result is only loaded when the output register is empty or draining
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |-> (!out_ch.valid || out_ch.ready))
    else $error("result loaded over a pending result");

  // The parser only consumes a byte that the input register holds
  a_step_held: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.step |-> item_valid)
    else $error("parser stepped without a held byte");

  // Entry index stays below the largest count
  a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.entry_index != {CountW{1'b1}}))
    else $error("entry index out of range");
endmodule

// File: tb/tile_update_record_parser_tb.sv
// Testbench for tile_update_record_parser: drives tile-update byte streams and
// checks every entry result against a behavioral parser kept in step here.
// Depends on trup_pkg, trup_if and the RTL of the block.
`timescale 1ns / 100ps

module tile_update_record_parser_tb;
  import trup_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 6;

  typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_t;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_wide_coordinates;

  trup_in_if  in_ch();
  trup_out_if out_ch();

  tile_update_record_parser u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_ch                (in_ch),
    .out_ch               (out_ch),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_wide_coordinates (cfg_wide_coordinates)
  );

  // Parser state as seen by the byte stream
  phase_t            ps_phase;
  logic              ps_wide;
  logic [CoordW-1:0] ps_x, ps_z;
  logic [LevelW-1:0] ps_level;
  logic [CountW-1:0] ps_total, ps_idx;
  logic              ps_zero_data;
  logic [ByteW-1:0]  ps_type, ps_xz, ps_height;
  logic              ps_type_next;

  result_t    pending_entries[$];
  int         mismatches;
  int         cycles;
  idle_mode_t tx_mode, rx_mode;
  int         rx_hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int draw_wait(idle_mode_t mode);
    case (mode)
      IDLE_NONE:  return 0;
      IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
      default:    return $urandom_range(0, 18);
    endcase
  endfunction

  task automatic close_entry(input logic [ByteW-1:0] data);
    result_t r;
    logic    last;
    last = ({1'b0, ps_idx} + 6'd1) >= {1'b0, ps_total};
    r.chunk_x     = ps_x;
    r.chunk_z     = ps_z;
    r.level_index = ps_level;
    r.entry_index = ps_idx;
    r.column_x    = ps_xz[7:4];
    r.column_z    = ps_xz[3:0];
    r.height      = ps_height;
    r.block_type  = ps_type;
    r.block_data  = data;
    r.last_entry  = last;
    pending_entries.push_back(r);
    if (last) begin
      ps_phase = PH_X0;
      ps_idx   = '0;
    end else begin
      ps_idx   = ps_idx + 1'b1;
      ps_phase = PH_XZ;
    end
  endtask

  task automatic parse_stream_byte(input logic [ByteW-1:0] b, input logic st);
    phase_t ph;
    ph = st ? PH_X0 : ps_phase;
    case (ph)
      PH_X1: begin
        ps_x[7:0] = b;
        ps_phase  = PH_Z0;
      end
      PH_Z0: begin
        if (ps_wide) begin
          ps_z     = {b, 8'h00};
          ps_phase = PH_Z1;
        end else begin
          ps_z     = {{(CoordW-ByteW){b[ByteW-1]}}, b};
          ps_phase = PH_FLAGS;
        end
      end
      PH_Z1: begin
        ps_z[7:0] = b;
        ps_phase  = PH_FLAGS;
      end
      PH_FLAGS: begin
        ps_zero_data = b[FlgAllZeroBit];
        ps_level     = b[FlgLevelLsb +: LevelW];
        ps_total     = b[CountW-1:0];
        ps_idx       = '0;
        ps_type      = TypeNone;
        ps_phase     = (ps_total == '0) ? PH_X0 : PH_XZ;
      end
      PH_XZ: begin
        ps_xz    = b;
        ps_phase = PH_EFLAG;
      end
      PH_EFLAG: begin
        ps_type_next = b[EflTypeBit];
        ps_phase     = PH_HEIGHT;
      end
      PH_HEIGHT: begin
        ps_height = b;
        if (ps_type_next) ps_phase = PH_TYPE;
        else if (ps_zero_data) close_entry('0);
        else ps_phase = PH_DATA;
      end
      PH_TYPE: begin
        ps_type = b;
        if (ps_zero_data) close_entry('0);
        else ps_phase = PH_DATA;
      end
      PH_DATA: close_entry(b);
      default: begin
        ps_type = TypeNone;
        ps_idx  = '0;
        if (ps_wide) begin
          ps_x     = {b, 8'h00};
          ps_phase = PH_X1;
        end else begin
          ps_x     = {{(CoordW-ByteW){b[ByteW-1]}}, b};
          ps_phase = PH_Z0;
        end
      end
    endcase
  endtask

  // Valid stays high after a transfer; the next call either drives the next
  // byte or drops valid for the drawn gap.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic st);
    int gap;
    gap = draw_wait(tx_mode);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.stream_byte  <= b;
    in_ch.packet_start <= st;
    do @(posedge clk); while (!in_ch.ready);
    parse_stream_byte(b, st);
  endtask

  task automatic tx_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    tx_idle();
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_wide(input logic v);
    wait_drained();
    @(negedge clk);
    cfg_valid            <= 1'b1;
    cfg_wide_coordinates <= v;
    do @(posedge clk); while (!cfg_ready);
    ps_wide = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed packets with random content; some are cut short or
  // followed by stray bytes, and the next packet then resyncs with start.
  task automatic send_random_packet(output int n_sent);
    logic [ByteW-1:0] pkt[$];
    logic [ByteW-1:0] flags, eflag;
    logic             first_start;
    int               count, cut, k;
    pkt = {};
    first_start = (ps_phase != PH_X0) || ($urandom_range(0, 1) == 1);
    repeat (ps_wide ? 4 : 2) pkt.push_back(8'($urandom));
    count = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 4);
    flags = 8'($urandom);
    flags[CountW-1:0] = 5'(count);
    pkt.push_back(flags);
    for (k = 0; k < count; k++) begin
      eflag = 8'($urandom);
      pkt.push_back(8'($urandom));
      pkt.push_back(eflag);
      pkt.push_back(8'($urandom));
      if (eflag[EflTypeBit]) pkt.push_back(8'($urandom));
      if (!flags[FlgAllZeroBit]) pkt.push_back(8'($urandom));
    end
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, pkt.size());
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
    if ($urandom_range(0, 14) == 0) begin
      repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
    end
    foreach (pkt[i]) send_byte(pkt[i], (i == 0) ? first_start : 1'b0);
    n_sent = pkt.size();
  endtask

  task automatic run_random(input int n_bytes, input logic cfg_changes);
    int sent, k;
    sent = 0;
    while (sent < n_bytes) begin
      if (cfg_changes && $urandom_range(0, 3) == 0) write_wide(1'($urandom_range(0, 1)));
      send_random_packet(k);
      sent += k;
    end
  endtask

  // Narrow coordinates at their extremes, ignored flag bits, end of packet
  // without start, all-zero data, mid-packet restart and a zero-count
  // packet.
  task automatic test_directed_narrow();
    tx_mode = IDLE_LIGHT;
    rx_mode = IDLE_LIGHT;
    write_wide(1'b0);
    send_byte(8'h80, 1'b1); send_byte(8'h7F, 1'b0); send_byte(8'h62, 1'b0);
    send_byte(8'hF0, 1'b0); send_byte(8'h7F, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h0F, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'hA2, 1'b0);
    send_byte(8'h5A, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h77, 1'b0);
    send_byte(8'hFF, 1'b1); send_byte(8'h01, 1'b0); send_byte(8'h00, 1'b0);
  endtask

  // Wide coordinates at their extremes, then a mode switch between the
  // first and second byte of the x coordinate.
  task automatic test_directed_wide();
    write_wide(1'b1);
    send_byte(8'h80, 1'b1); send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h41, 1'b0);
    send_byte(8'h12, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h12, 1'b1);
    write_wide(1'b0);
    send_byte(8'h34, 1'b0); send_byte(8'h85, 1'b0); send_byte(8'h81, 1'b0);
    send_byte(8'hC3, 1'b0); send_byte(8'h01, 1'b0); send_byte(8'h99, 1'b0);
  endtask

  task automatic test_random_narrow();
    tx_mode = IDLE_HEAVY;
    rx_mode = IDLE_HEAVY;
    write_wide(1'b0);
    run_random(180, 1'b0);
  endtask

  task automatic test_random_wide();
    tx_mode = IDLE_NONE;
    rx_mode = IDLE_NONE;
    write_wide(1'b1);
    run_random(180, 1'b0);
  endtask

  // Receiver stalls long while bytes keep coming, so the block backs up.
  task automatic test_backpressure();
    tx_mode     = IDLE_NONE;
    rx_mode     = IDLE_LIGHT;
    rx_hold_req = 300;
    run_random(80, 1'b0);
  endtask

  task automatic test_sender_pause();
    tx_mode = IDLE_LIGHT;
    rx_mode = IDLE_HEAVY;
    repeat (3) begin
      run_random(30, 1'b0);
      wait_drained();
    end
  endtask

  task automatic test_config_mix();
    tx_mode = IDLE_LIGHT;
    rx_mode = IDLE_LIGHT;
    run_random(220, 1'b1);
  endtask

  function automatic void check_field(string name, logic [CoordW-1:0] exp_v,
                                      logic [CoordW-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // Result receiver and checker
  initial begin
    result_t exp_r;
    int      stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = (rx_hold_req > 0) ? rx_hold_req : draw_wait(rx_mode);
      rx_hold_req = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (pending_entries.size() == 0) begin
        $error("result transfer with no entry expected");
        mismatches++;
      end else begin
        exp_r = pending_entries.pop_front();
        check_field("chunk_x", exp_r.chunk_x, out_ch.chunk_x);
        check_field("chunk_z", exp_r.chunk_z, out_ch.chunk_z);
        check_field("level_index", CoordW'(exp_r.level_index),
                    CoordW'(out_ch.level_index));
        check_field("entry_index", CoordW'(exp_r.entry_index),
                    CoordW'(out_ch.entry_index));
        check_field("column_x", CoordW'(exp_r.column_x), CoordW'(out_ch.column_x));
        check_field("column_z", CoordW'(exp_r.column_z), CoordW'(out_ch.column_z));
        check_field("height", CoordW'(exp_r.height), CoordW'(out_ch.height));
        check_field("block_type", CoordW'(exp_r.block_type),
                    CoordW'(out_ch.block_type));
        check_field("block_data", CoordW'(exp_r.block_data),
                    CoordW'(out_ch.block_data));
        check_field("last_entry", CoordW'(exp_r.last_entry),
                    CoordW'(out_ch.last_entry));
      end
    end
  end

  initial begin
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.stream_byte    <= '0;
    in_ch.packet_start   <= 1'b0;
    cfg_valid            <= 1'b0;
    cfg_wide_coordinates <= 1'b0;
    mismatches   = 0;
    cycles       = 0;
    rx_hold_req  = 0;
    tx_mode      = IDLE_NONE;
    rx_mode      = IDLE_NONE;
    ps_phase     = PH_X0;
    ps_wide      = 1'b0;
    ps_x         = '0;
    ps_z         = '0;
    ps_level     = '0;
    ps_total     = '0;
    ps_idx       = '0;
    ps_zero_data = 1'b0;
    ps_type      = TypeNone;
    ps_xz        = '0;
    ps_type_next = 1'b0;
    ps_height    = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_narrow();
    test_directed_wide();
    test_random_narrow();
    test_random_wide();
    test_backpressure();
    test_sender_pause();
    test_config_mix();
    wait_drained();

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/trup_pkg.sv
rtl/trup_if.sv
rtl/trup_in_stage.sv
rtl/trup_parser.sv
rtl/trup_out_stage.sv
rtl/tile_update_record_parser.sv
tb/tile_update_record_parser_tb.sv
